>>> src/segmented_led_level_meter_assert.svh
// Assertion macros used by the level meter RTL.
// Depends on nothing; included by the modules that carry checks.
`ifndef SEGMENTED_LED_LEVEL_METER_ASSERT_SVH
`define SEGMENTED_LED_LEVEL_METER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define SLM_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SLM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/slm_pkg.sv
// Types and constants of the segmented LED level meter.
// Used by the front, queue, back and top-level modules; depends on nothing.
package slm_pkg;

   // Width of a beam length, a lit count and an LED position.
   localparam int LEN_W = 5;
   // Depth of the beam queue between front and back.
   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   // Level thresholds in units of 1/16 dB.
   localparam logic signed [11:0] LVL_20DB = 12'sd320;
   localparam logic signed [11:0] LVL_45DB = 12'sd720;
   localparam logic signed [11:0] LVL_70DB = 12'sd1120;

   // Frame delimiters.
   localparam logic [31:0] START_WORD = 32'h0000_0000;
   localparam logic [31:0] END_WORD   = 32'hFFFF_FFFF;

   // Configuration register indexes.
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_GREEN  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_YELLOW = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ORANGE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RED    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_OFF    = 3'd4;

   typedef struct packed {
      logic signed [11:0] level_db;
      logic [4:0]         beam_length;
      logic               reversed;
      logic               last_beam;
   } req_type;

   typedef struct packed {
      logic [31:0] led_word;
      logic        last_word;
   } rsp_type;

   // One classified beam, as handed from the front to the back.
   typedef struct packed {
      logic             start;   // start word goes first
      logic             fin;     // end word goes last
      logic             rev;
      logic [LEN_W-1:0] len;     // saturated LED count
      logic [LEN_W-1:0] lit;     // lit LED count
      logic [LEN_W-1:0] s1;      // top of the green band
      logic [LEN_W-1:0] s2;      // top of the yellow band
      logic [LEN_W-1:0] s3;      // top of the orange band
   } desc_type;

   // Queue status seen by the front and the back.
   typedef struct packed {
      logic full;
      logic valid;
   } q_stat_type;

endpackage

>>> src/slm_front.sv
// Front part of the level meter: accepts requests, quantizes the level and
// tracks frame state. Depends on slm_pkg.
module slm_front
   import slm_pkg::*;
#(
   parameter int MAX_BEAM_LEDS = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  q_stat_type q_stat,
   input  req_type    req_data,
   output logic       desc_push,
   output desc_type   desc
);

   logic             frame_open_ff;
   logic             frame_open_in;
   logic [LEN_W-1:0] len;
   logic [LEN_W-1:0] q1;
   logic [LEN_W-1:0] s1;

   assign desc_push = push && !q_stat.full;

   // Saturate the beam length and derive the lit count and colour bands.
   always_comb begin
      if (int'(req_data.beam_length) > MAX_BEAM_LEDS) begin
         len = LEN_W'(MAX_BEAM_LEDS);
      end else begin
         len = req_data.beam_length;
      end
      q1 = len >> 2;
      // One extra bit keeps the rounding sum from wrapping on the longest beams.
      s1 = LEN_W'(({1'b0, len} + (LEN_W + 1)'(2)) >> 2);

      desc.start = !frame_open_ff;
      desc.fin   = req_data.last_beam;
      desc.rev   = req_data.reversed;
      desc.len   = len;
      desc.s1    = s1;
      desc.s2    = s1 << 1;
      desc.s3    = (s1 << 1) + s1;

      if (req_data.level_db >= LVL_70DB) begin
         desc.lit = len;
      end else if (req_data.level_db < 12'sd0) begin
         desc.lit = '0;
      end else if (req_data.level_db <= LVL_20DB) begin
         desc.lit = q1;
      end else if (req_data.level_db <= LVL_45DB) begin
         desc.lit = q1 << 1;
      end else begin
         desc.lit = (q1 << 1) + q1;
      end
   end

   // A beam that ends the frame makes the next beam open a new one.
   always_comb begin
      frame_open_in = frame_open_ff;
      if (desc_push) begin
         frame_open_in = !req_data.last_beam;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_open_ff <= 1'b0;
      end else begin
         frame_open_ff <= frame_open_in;
      end
   end

endmodule

>>> src/slm_queue.sv
// Short beam queue between the front and the back of the level meter.
// Depends on slm_pkg.
module slm_queue
   import slm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       wr_en,
   input  desc_type   wr_data,
   input  logic       rd_en,
   output q_stat_type q_stat,
   output desc_type   rd_data
);

   desc_type             entry_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff;
   logic [Q_PTR_W-1:0]   wr_ptr_in;
   logic [Q_PTR_W-1:0]   rd_ptr_ff;
   logic [Q_PTR_W-1:0]   rd_ptr_in;
   logic [Q_CNT_W-1:0]   count_ff;
   logic [Q_CNT_W-1:0]   count_in;

   assign q_stat.full  = (count_ff == Q_CNT_W'(Q_DEPTH));
   assign q_stat.valid = (count_ff != '0);
   assign rd_data      = entry_ff[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (wr_en && !rd_en) begin
         count_in = count_ff + 1'b1;
      end else if (rd_en && !wr_en) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

>>> src/slm_back.sv
// Back part of the level meter: walks one queued beam word by word and
// holds the colour registers and the output register. Depends on slm_pkg.
`include "segmented_led_level_meter_assert.svh"

module slm_back
   import slm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  q_stat_type           q_stat,
   input  desc_type             head,
   output logic                 q_pop,
   input  logic                 pop,
   output logic                 empty,
   output rsp_type              rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_wdata
);

   typedef enum logic {PH_START, PH_BODY} phase_type;
   typedef enum logic [1:0] {K_NONE, K_START, K_LED, K_END} kind_type;

   phase_type        phase_ff;
   phase_type        phase_in;
   logic [LEN_W-1:0] led_idx_ff;
   logic [LEN_W-1:0] led_idx_in;
   logic             rsp_valid_ff;
   rsp_type          rsp_data_ff;

   logic [31:0] green_ff, yellow_ff, orange_ff, red_ff, off_ff;

   kind_type         kind;
   logic             slot_free;
   logic             emit;
   logic             word_last;
   logic             led_lit;
   logic [LEN_W-1:0] pos;
   logic [LEN_W-1:0] unlit;
   logic [31:0]      lit_word;
   logic [31:0]      word;

   assign empty     = !rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign slot_free = !rsp_valid_ff || pop;
   assign unlit     = head.len - head.lit;

   // Pick the next word of the beam at the head of the queue.
   always_comb begin
      if (!q_stat.valid) begin
         kind = K_NONE;
      end else if (phase_ff == PH_START && head.start) begin
         kind = K_START;
      end else if (led_idx_ff < head.len) begin
         kind = K_LED;
      end else if (head.fin) begin
         kind = K_END;
      end else begin
         kind = K_NONE;
      end
   end

   // Whether this LED is lit and its position from the bottom of the beam.
   always_comb begin
      if (!head.rev) begin
         led_lit = (led_idx_ff < head.lit);
         pos     = led_idx_ff + 1'b1;
      end else begin
         led_lit = (led_idx_ff >= unlit);
         pos     = head.len - led_idx_ff;
      end
   end

   // Colour band of a lit LED; the top LED is always red.
   always_comb begin
      if (pos == head.len) begin
         lit_word = red_ff;
      end else if (pos <= head.s1) begin
         lit_word = green_ff;
      end else if (pos <= head.s2) begin
         lit_word = yellow_ff;
      end else if (pos <= head.s3) begin
         lit_word = orange_ff;
      end else begin
         lit_word = red_ff;
      end
   end

   // Word value and whether it closes the request's results.
   always_comb begin
      case (kind)
         K_START: begin
            word      = START_WORD;
            word_last = (head.len == '0) && !head.fin;
         end
         K_LED: begin
            word      = led_lit ? lit_word : off_ff;
            word_last = (led_idx_ff + 1'b1 == head.len) && !head.fin;
         end
         K_END: begin
            word      = END_WORD;
            word_last = 1'b1;
         end
         default: begin
            word      = off_ff;
            word_last = 1'b0;
         end
      endcase
   end

   assign emit  = (kind != K_NONE) && slot_free;
   // A beam with no words at all is dropped without using the output slot.
   assign q_pop = q_stat.valid && ((kind == K_NONE) || (emit && word_last));

   // Sequencer progress through the head beam.
   always_comb begin
      phase_in   = phase_ff;
      led_idx_in = led_idx_ff;
      if (q_pop) begin
         phase_in   = PH_START;
         led_idx_in = '0;
      end else if (emit) begin
         phase_in = PH_BODY;
         if (kind == K_LED) begin
            led_idx_in = led_idx_ff + 1'b1;
         end
      end
   end

   // Sequencer state and output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_START;
         led_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         led_idx_ff <= led_idx_in;
         if (emit) begin
            rsp_valid_ff          <= 1'b1;
            rsp_data_ff.led_word  <= word;
            rsp_data_ff.last_word <= word_last;
         end else if (pop) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Colour registers; unknown indexes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         green_ff  <= '0;
         yellow_ff <= '0;
         orange_ff <= '0;
         red_ff    <= '0;
         off_ff    <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_GREEN:  green_ff  <= csr_wdata;
            CSR_YELLOW: yellow_ff <= csr_wdata;
            CSR_ORANGE: orange_ff <= csr_wdata;
            CSR_RED:    red_ff    <= csr_wdata;
            CSR_OFF:    off_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // The LED counter never runs past the beam it walks.
   `SLM_ASSERT_IMPLY(a_idx_in_beam, clock, reset, q_stat.valid, led_idx_ff <= head.len, "LED index beyond beam length")
   // With no beam queued the sequencer rests at its starting point.
   `SLM_ASSERT_IMPLY(a_idle_rest, clock, reset, !q_stat.valid, (phase_ff == PH_START) && (led_idx_ff == '0), "sequencer not at rest while queue is empty")
   // A word written to the output slot is shown in the next cycle.
   `SLM_ASSERT_NEXT(a_emit_shown, clock, reset, emit, !empty, "emitted word not presented")
   // The front never marks more LEDs lit than the beam has.
   `SLM_ASSERT_IMPLY(a_lit_le_len, clock, reset, q_stat.valid, head.lit <= head.len, "lit count exceeds beam length")

endmodule

>>> src/segmented_led_level_meter.sv
// Segmented LED level meter top level: front, beam queue and back.
// Depends on slm_pkg, slm_front, slm_queue and slm_back.
//
// Usage: a beam request (level, LED count, mounting direction, last-beam
// flag) is written with push while full is low. The meter answers with a
// stream of 32-bit LED words read with pop while empty is low: a start word
// before the first beam of a frame, one word per LED in strip order, and an
// end word after a beam that closes the frame. last_word marks the final
// word of each request; a request that yields no word gives no response.
// The first word of a beam passes the beam queue and the output register
// before it shows on the response port when the back is idle. The back
// sequencer emits one word per cycle while the output slot is free: any
// start word, one word per LED and any end word; a beam with no words is
// dropped from the queue. A two-entry beam queue lets requests be taken
// while the back works. Reset clears the colour registers to zero, empties
// queue and output, and makes the next beam open a frame. When the receiver
// holds pop low the output word stays put, the back stalls and the queue
// fills up to full. The user writes the colour registers through the csr
// port while the meter is idle; the block itself does not enforce it.
module segmented_led_level_meter
   import slm_pkg::*;
#(
   parameter int MAX_BEAM_LEDS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   output logic                 full,
   input  req_type              req_data,
   input  logic                 pop,
   output logic                 empty,
   output rsp_type              rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_wdata
);

   q_stat_type q_stat;
   desc_type   desc;
   desc_type   head;
   logic       desc_push;
   logic       q_pop;

   assign full = q_stat.full;

   slm_front #(
      .MAX_BEAM_LEDS(MAX_BEAM_LEDS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .q_stat   (q_stat),
      .req_data (req_data),
      .desc_push(desc_push),
      .desc     (desc)
   );

   slm_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .wr_en  (desc_push),
      .wr_data(desc),
      .rd_en  (q_pop),
      .q_stat (q_stat),
      .rd_data(head)
   );

   slm_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_stat   (q_stat),
      .head     (head),
      .q_pop    (q_pop),
      .pop      (pop),
      .empty    (empty),
      .rsp_data (rsp_data),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

endmodule
